[hw/rtl/u8sf_pkg.sv]
// Package for the UTF-8 sequence filter: beat types, byte constants and the
// lead byte decoder. No dependencies.
`default_nettype none

package u8sf_pkg;

   // Request beat: one raw byte of the string
   typedef struct packed {
      logic [7:0] in_byte;
      logic       string_end;
   } req_type;

   // Response beat: one filtered byte
   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       string_last;
      logic       string_valid;
   } rsp_type;

   localparam logic [7:0] QMARK     = 8'h3F;
   localparam logic [1:0] CONT_TAG  = 2'b10;
   localparam int         SEQ_DEPTH = 6;

   // Decode the sequence length from a lead byte; zero when not a lead byte
   function automatic logic [2:0] lead_length(input logic [7:0] b);
      logic [2:0] len;
      len = 3'd0;
      priority if ((b & 8'hFE) == 8'hFC) len = 3'd6;
      else if ((b & 8'hFC) == 8'hF8)     len = 3'd5;
      else if ((b & 8'hF8) == 8'hF0)     len = 3'd4;
      else if ((b & 8'hF0) == 8'hE0)     len = 3'd3;
      else if ((b & 8'hE0) == 8'hC0)     len = 3'd2;
      else                               len = 3'd0;
      return len;
   endfunction

endpackage

`default_nettype wire

[hw/rtl/utf8_sequence_filter_unit.sv]
// UTF-8 sequence filter: validates a byte stream and replaces bad sequences.
// An accepted request beat sets up the drain registers; the output register then
// takes the first response beat. An item that causes n responses (n = 0..6) holds the
// request side until its last response is loaded; the drain counter walks the sequence
// buffer one byte a cycle unless the output stalls. Reset: sequence state cleared,
// string flag set, output register empty; the sequence buffer is not cleared. Depends on u8sf_pkg.
`default_nettype none

module utf8_sequence_filter_unit (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_valid,
   output logic             req_stall,
   input  wire u8sf_pkg::req_type req_beat,
   output logic             rsp_valid,
   input  wire              rsp_stall,
   output u8sf_pkg::rsp_type rsp_beat
);

   localparam logic ST_IDLE  = 1'b0;
   localparam logic ST_DRAIN = 1'b1;

   // Sequencer and sequence state
   logic       state_ff, state_in;
   logic [2:0] seq_exp_ff, seq_exp_in;
   logic [2:0] seq_rec_ff, seq_rec_in;
   logic       seq_bad_ff, seq_bad_in;
   logic       all_ok_ff, all_ok_in;

   // Drain control
   logic [2:0] emit_idx_ff, emit_idx_in;
   logic [2:0] emit_cnt_ff, emit_cnt_in;
   logic       emit_qm_ff, emit_qm_in;
   logic       emit_end_ff, emit_end_in;
   logic       emit_ok_ff, emit_ok_in;

   // Sequence buffer, one write port, one read port
   logic [7:0] seq_buf_ff [u8sf_pkg::SEQ_DEPTH];
   logic       buf_wr_en;
   logic [2:0] buf_wr_idx;

   // Output register
   logic              rsp_valid_ff, rsp_valid_in;
   u8sf_pkg::rsp_type rsp_beat_ff, rsp_beat_in;

   logic       req_accept;
   logic       out_load;
   logic       emit_final;
   logic [2:0] lead_len;
   logic [2:0] rec_next;
   logic       bad_next;
   logic       ok_upd;
   logic [2:0] emit_n;
   logic       emit_qm;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_beat   = rsp_beat_ff;

   assign lead_len   = u8sf_pkg::lead_length(req_beat.in_byte);
   assign rec_next   = 3'(seq_rec_ff + 3'd1);
   assign bad_next   = seq_bad_ff || (req_beat.in_byte[7:6] != u8sf_pkg::CONT_TAG);
   assign out_load   = (state_ff == ST_DRAIN) && (!rsp_valid_ff || !rsp_stall);
   assign emit_final = (emit_idx_ff == 3'(emit_cnt_ff - 3'd1));

   // Classify the accepted byte and set up the drain, or advance a running drain
   always_comb begin
      state_in    = state_ff;
      seq_exp_in  = seq_exp_ff;
      seq_rec_in  = seq_rec_ff;
      seq_bad_in  = seq_bad_ff;
      all_ok_in   = all_ok_ff;
      emit_idx_in = emit_idx_ff;
      emit_cnt_in = emit_cnt_ff;
      emit_qm_in  = emit_qm_ff;
      emit_end_in = emit_end_ff;
      emit_ok_in  = emit_ok_ff;
      buf_wr_en   = 1'b0;
      buf_wr_idx  = 3'd0;
      emit_n      = 3'd0;
      emit_qm     = 1'b0;
      ok_upd      = all_ok_ff;

      if (req_accept) begin
         buf_wr_en = 1'b1;
         if (seq_exp_ff == 3'd0) begin
            buf_wr_idx = 3'd0;
            if (!req_beat.in_byte[7]) begin
               emit_n = 3'd1;
            end else if ((lead_len == 3'd0) || req_beat.string_end) begin
               emit_n  = 3'd1;
               emit_qm = 1'b1;
               ok_upd  = 1'b0;
            end else begin
               seq_exp_in = lead_len;
               seq_rec_in = 3'd1;
               seq_bad_in = 1'b0;
            end
         end else begin
            buf_wr_idx = seq_rec_ff;
            if (rec_next >= seq_exp_ff) begin
               emit_n     = seq_exp_ff;
               emit_qm    = bad_next;
               ok_upd     = all_ok_ff && !bad_next;
               seq_exp_in = 3'd0;
               seq_rec_in = 3'd0;
               seq_bad_in = 1'b0;
            end else if (req_beat.string_end) begin
               emit_n     = rec_next;
               emit_qm    = 1'b1;
               ok_upd     = 1'b0;
               seq_exp_in = 3'd0;
               seq_rec_in = 3'd0;
               seq_bad_in = 1'b0;
            end else begin
               seq_rec_in = rec_next;
               seq_bad_in = bad_next;
            end
         end

         // Close the string: restart the flag and drop any open sequence
         all_ok_in = ok_upd;
         if (req_beat.string_end) begin
            all_ok_in  = 1'b1;
            seq_exp_in = 3'd0;
            seq_rec_in = 3'd0;
            seq_bad_in = 1'b0;
         end

         if (emit_n != 3'd0) begin
            state_in    = ST_DRAIN;
            emit_idx_in = 3'd0;
            emit_cnt_in = emit_n;
            emit_qm_in  = emit_qm;
            emit_end_in = req_beat.string_end;
            emit_ok_in  = ok_upd;
         end
      end else if (out_load) begin
         // Advance through the buffered bytes
         emit_idx_in = 3'(emit_idx_ff + 3'd1);
         if (emit_final) begin
            state_in = ST_IDLE;
         end
      end
   end

   // Build the next response beat
   always_comb begin
      rsp_beat_in  = rsp_beat_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (out_load) begin
         rsp_valid_in             = 1'b1;
         rsp_beat_in.out_byte     = emit_qm_ff ? u8sf_pkg::QMARK : seq_buf_ff[emit_idx_ff];
         rsp_beat_in.run_last     = emit_final;
         rsp_beat_in.string_last  = emit_final && emit_end_ff;
         rsp_beat_in.string_valid = emit_final && emit_end_ff && emit_ok_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seq_exp_ff   <= 3'd0;
         seq_rec_ff   <= 3'd0;
         seq_bad_ff   <= 1'b0;
         all_ok_ff    <= 1'b1;
         emit_idx_ff  <= 3'd0;
         emit_cnt_ff  <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seq_exp_ff   <= seq_exp_in;
         seq_rec_ff   <= seq_rec_in;
         seq_bad_ff   <= seq_bad_in;
         all_ok_ff    <= all_ok_in;
         emit_idx_ff  <= emit_idx_in;
         emit_cnt_ff  <= emit_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      emit_qm_ff  <= emit_qm_in;
      emit_end_ff <= emit_end_in;
      emit_ok_ff  <= emit_ok_in;
      rsp_beat_ff <= rsp_beat_in;
   end

   // Sequence buffer write
   always_ff @(posedge clock) begin
      if (buf_wr_en) begin
         seq_buf_ff[buf_wr_idx] <= req_beat.in_byte;
      end
   end

   // Drain index stays inside the run
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |-> (emit_idx_ff < emit_cnt_ff))
      else $error("drain index past run length");

   // Open sequence has taken at least its lead and is still short
   assert property (@(posedge clock) disable iff (reset)
      (seq_exp_ff != 3'd0) |-> ((seq_rec_ff != 3'd0) && (seq_rec_ff < seq_exp_ff)))
      else $error("sequence counters inconsistent");

   // String end only on the last beat of a run
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_beat_ff.string_last |-> rsp_beat_ff.run_last)
      else $error("string end not on run end");

   // A string-ending request always produces a drain
   assert property (@(posedge clock) disable iff (reset)
      req_accept && req_beat.string_end |=> (state_ff == ST_DRAIN) && emit_end_ff)
      else $error("string end produced no response");

endmodule

`default_nettype wire
